// ----- hdl/salc_pkg.sv -----
`timescale 1ns / 1ps

package salc_pkg;

    // Defaults for the top-level geometry parameters
    localparam int DEF_MAX_SET_BITS = 8;
    localparam int DEF_MAX_WAYS     = 8;

    // Upper bound on ways; sizes the way fields of the scan result
    localparam int MAX_WAYS_LIMIT = 16;
    localparam int WAY_FW         = $clog2(MAX_WAYS_LIMIT);

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int TOT_W      = 32;
    localparam int KIND_W     = 2;
    localparam int AGE_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Result tdata: hit, miss, evicted, three totals, padded to whole bytes
    localparam int OUT_RAW_W   = 3 + 3 * TOT_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_RAW_W;

    // Age ranks saturate here; a fresh fill ages every younger valid way
    localparam logic [AGE_W-1:0] RANK_MAX   = 3'd7;
    localparam logic [AGE_W:0]   RANK_FRESH = 4'd8;

    // Access kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_MODIFY = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_WAYS        = 2'd2
    } t_cfg_idx;

    // Outcome of one way scan over a set
    typedef struct packed {
        logic              hit;
        logic [WAY_FW-1:0] hit_way;
        logic [AGE_W-1:0]  hit_age;
        logic              inv_found;
        logic [WAY_FW-1:0] inv_way;
        logic [WAY_FW-1:0] lru_way;
        logic [AGE_W-1:0]  lru_age;
    } t_scan_res;

endpackage

// ----- hdl/salc_row_ram.sv -----
`timescale 1ns / 1ps

// One row per set: simple dual-port memory with registered read data
module salc_row_ram #(
    parameter int AW    = 8,
    parameter int DEPTH = 256,
    parameter int DW    = 288
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/salc_way_scan.sv -----
`timescale 1ns / 1ps

// Way-serial scan: one tag compare per cycle, tracking hit, first free way and LRU way
module salc_way_scan import salc_pkg::*; #(
    parameter int MAX_WAYS = DEF_MAX_WAYS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [$clog2(MAX_WAYS+1)-1:0]        i_ways,
    input  logic [ADDR_W-1:0]                    i_tag,
    input  logic [MAX_WAYS-1:0]                  i_valid,
    input  logic [MAX_WAYS-1:0][AGE_W-1:0]       i_age,
    input  logic [MAX_WAYS-1:0][ADDR_W-1:0]      i_tags,
    output logic                                 o_done,
    output t_scan_res                            o_res
);

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W = $clog2(MAX_WAYS + 1);

    logic             r_busy;
    logic             r_done;
    logic [WAY_W-1:0] r_w;
    t_scan_res        r_res;

    logic w_match;
    logic w_last_way;

    // Compare the current way
    assign w_match    = i_valid[r_w] && (i_tags[r_w] == i_tag);
    assign w_last_way = (CNT_W'(r_w) + CNT_W'(1)) == i_ways;

    // Sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (w_match || w_last_way)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Way counter and running outcome
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w           <= '0;
            r_res.hit     <= 1'b0;
            r_res.inv_found <= 1'b0;
        end else if (r_busy) begin
            r_w <= r_w + WAY_W'(1);
            if (w_match) begin
                r_res.hit     <= 1'b1;
                r_res.hit_way <= WAY_FW'(r_w);
                r_res.hit_age <= i_age[r_w];
            end
            if (!r_res.inv_found && !i_valid[r_w]) begin
                r_res.inv_found <= 1'b1;
                r_res.inv_way   <= WAY_FW'(r_w);
            end
            // Strictly older wins, so ties keep the lowest way
            if ((r_w == '0) || (i_age[r_w] > r_res.lru_age)) begin
                r_res.lru_way <= WAY_FW'(r_w);
                r_res.lru_age <= i_age[r_w];
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- hdl/set_assoc_lru_cache_sim.sv -----
`timescale 1ns / 1ps
// Sequence: an input transfer moves through the states READ, SCAN and UPDATE to its result;
//   SCAN compares 1 up to the ways in use (one tag comparator checks one way per cycle).
// Input: the next input is taken once the result (for a modify, both results) is in the output register.
// Reset (synchronous, active low) clears control, totals and configuration, then a
//   clearing pass writes every set row with s_axis_tready low.
module set_assoc_lru_cache_sim import salc_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Input items
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [ADDR_W-1:0]       s_axis_tdata,   // [31:0] addr
    input  logic [KIND_W-1:0]       s_axis_tuser,   // [1:0] kind
    // Results
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // [0] hit, [1] miss, [2] evicted,
                                                    // [34:3] hit_total, [66:35] miss_total,
                                                    // [98:67] evict_total, rest zero
    output logic                    m_axis_tlast,   // last
    // Configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ROWS   = 1 << MAX_SET_BITS;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W  = $clog2(MAX_WAYS + 1);
    localparam int ROW_W  = MAX_WAYS * (1 + AGE_W + ADDR_W);
    localparam int VA_W   = MAX_WAYS * (1 + AGE_W);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_READ   = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_SECOND = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [3:0]         r_cfg_sib;
    logic [4:0]         r_cfg_bob;
    logic [3:0]         r_cfg_wiu;

    logic [SET_AW-1:0]  r_clr;
    logic [SET_AW-1:0]  r_set;
    logic [ADDR_W-1:0]  r_tag;
    logic               r_modify;

    logic               r_out_valid;
    logic               r_out_hit;
    logic               r_out_evict;
    logic               r_out_last;
    logic [TOT_W-1:0]   r_hits;
    logic [TOT_W-1:0]   r_misses;
    logic [TOT_W-1:0]   r_evicts;

    logic [3:0]         w_eff_s;
    logic [CNT_W-1:0]   w_eff_ways;
    logic [5:0]         w_sh;
    logic [ADDR_W-1:0]  w_set_full;
    logic [ADDR_W-1:0]  w_tag;

    logic               w_in_xfer;
    logic               w_out_free;
    logic               w_we;
    logic [SET_AW-1:0]  w_waddr;
    logic [ROW_W-1:0]   w_wdata;
    logic               w_re;
    logic [ROW_W-1:0]   w_rdata;
    logic               w_scan_start;
    logic               w_scan_done;
    t_scan_res          w_res;
    logic               w_load1;
    logic               w_load2;

    logic [MAX_WAYS-1:0]               w_rd_valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]    w_rd_age;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]   w_rd_tag;
    logic [MAX_WAYS-1:0]               w_new_valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]    w_new_age;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]   w_new_tag;
    logic [WAY_W-1:0]                  w_target;
    logic [AGE_W:0]                    w_old_rank;
    logic                              w_evict;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sib <= 4'd0;
            r_cfg_bob <= 5'd0;
            r_cfg_wiu <= 4'd1;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SET_BITS:    r_cfg_sib <= i_cfg_data[3:0];
                CFG_OFFSET_BITS: r_cfg_bob <= i_cfg_data;
                CFG_WAYS:        r_cfg_wiu <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Effective geometry
    always_comb begin
        w_eff_s = (r_cfg_sib > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : r_cfg_sib;
        if (r_cfg_wiu == 4'd0) begin
            w_eff_ways = CNT_W'(1);
        end else if ({1'b0, r_cfg_wiu} > 5'(MAX_WAYS)) begin
            w_eff_ways = CNT_W'(MAX_WAYS);
        end else begin
            w_eff_ways = CNT_W'(r_cfg_wiu);
        end
    end

    // Set index and tag of the incoming address
    assign w_sh       = {1'b0, r_cfg_bob} + {2'b00, w_eff_s};
    assign w_set_full = (s_axis_tdata >> r_cfg_bob) & ~(32'hFFFF_FFFF << w_eff_s);
    assign w_tag      = (w_sh >= 6'd32) ? '0 : (s_axis_tdata >> w_sh);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // Row storage
    salc_row_ram #(
        .AW    (SET_AW),
        .DEPTH (ROWS),
        .DW    (ROW_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_set),
        .o_rdata (w_rdata)
    );

    assign w_rd_valid = w_rdata[MAX_WAYS-1:0];
    assign w_rd_age   = w_rdata[VA_W-1:MAX_WAYS];
    assign w_rd_tag   = w_rdata[ROW_W-1:VA_W];

    // Shared tag comparator
    salc_way_scan #(
        .MAX_WAYS (MAX_WAYS)
    ) u_way_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_scan_start),
        .i_ways  (w_eff_ways),
        .i_tag   (r_tag),
        .i_valid (w_rd_valid),
        .i_age   (w_rd_age),
        .i_tags  (w_rd_tag),
        .o_done  (w_scan_done),
        .o_res   (w_res)
    );

    // Row update: fill or touch the target way, age the younger valid ways
    always_comb begin
        w_evict = !w_res.hit && !w_res.inv_found;
        if (w_res.hit) begin
            w_target   = w_res.hit_way[WAY_W-1:0];
            w_old_rank = {1'b0, w_res.hit_age};
        end else if (w_res.inv_found) begin
            w_target   = w_res.inv_way[WAY_W-1:0];
            w_old_rank = RANK_FRESH;
        end else begin
            w_target   = w_res.lru_way[WAY_W-1:0];
            w_old_rank = {1'b0, w_res.lru_age};
        end
        w_new_valid = w_rd_valid;
        w_new_age   = w_rd_age;
        w_new_tag   = w_rd_tag;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (WAY_W'(j) == w_target) begin
                w_new_age[j] = '0;
                if (!w_res.hit) begin
                    w_new_valid[j] = 1'b1;
                    w_new_tag[j]   = r_tag;
                end
            end else if ((CNT_W'(j) < w_eff_ways) && w_rd_valid[j] &&
                         ({1'b0, w_rd_age[j]} < w_old_rank) && (w_rd_age[j] != RANK_MAX)) begin
                w_new_age[j] = w_rd_age[j] + AGE_W'(1);
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        w_re         = 1'b0;
        w_scan_start = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_set;
        w_wdata      = {w_new_tag, w_new_age, w_new_valid};
        w_load1      = 1'b0;
        w_load2      = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                if (r_clr == SET_AW'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_xfer && (t_kind'(s_axis_tuser) != KIND_UNUSED)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                w_re         = 1'b1;
                w_scan_start = 1'b1;
                n_state      = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (w_out_free) begin
                    w_we    = 1'b1;
                    w_load1 = 1'b1;
                    n_state = r_modify ? ST_SECOND : ST_IDLE;
                end
            end
            ST_SECOND: begin
                // Second access of a modify: same line, always a hit, ranks unchanged
                if (w_out_free) begin
                    w_load2 = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + SET_AW'(1);
            end
        end
    end

    // Capture the access
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_set    <= w_set_full[SET_AW-1:0];
            r_tag    <= w_tag;
            r_modify <= (t_kind'(s_axis_tuser) == KIND_MODIFY);
        end
    end

    // Output register and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
        end else begin
            if (w_load1 || w_load2) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load1) begin
                if (w_res.hit) begin
                    r_hits <= r_hits + TOT_W'(1);
                end else begin
                    r_misses <= r_misses + TOT_W'(1);
                end
                if (w_evict) begin
                    r_evicts <= r_evicts + TOT_W'(1);
                end
            end else if (w_load2) begin
                r_hits <= r_hits + TOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load1) begin
            r_out_hit   <= w_res.hit;
            r_out_evict <= w_evict;
            r_out_last  <= !r_modify;
        end else if (w_load2) begin
            r_out_hit   <= 1'b1;
            r_out_evict <= 1'b0;
            r_out_last  <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_evicts, r_misses, r_hits,
                            r_out_evict, !r_out_hit, r_out_hit};

endmodule

// ----- hdl/salc_checker.sv -----
`timescale 1ns / 1ps

// Port-level checks for the cache
module salc_checker import salc_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    s_axis_tready,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                    m_axis_tlast
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Hit and miss are exclusive and one is always set
    a_hit_xor_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] != m_axis_tdata[1]))
        else $error("hit and miss disagree");

    // An eviction only comes with a miss
    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
        else $error("eviction without miss");

    // The first result of a modify is followed at once by its final hit
    a_modify_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tlast && m_axis_tdata[0])
        else $error("second result of modify missing or not a hit");

    // No input is taken in the cycle right after reset: the clearing pass runs
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("input ready during clearing pass");

endmodule

bind set_assoc_lru_cache_sim salc_checker u_salc_checker (.*);

// ----- tb/tb_set_assoc_lru_cache_sim.sv -----
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_sim;
    import salc_pkg::*;

    localparam int SET_BITS_MAX = DEF_MAX_SET_BITS;
    localparam int NWAYS        = DEF_MAX_WAYS;
    localparam int NLINES       = (1 << SET_BITS_MAX) * NWAYS;
    localparam int DRAIN_CYCLES = 32;       // covers the slowest scan plus output stall
    localparam int LIMIT_CYCLES = 500000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 140;

    // One result of one cache access
    typedef struct packed {
        logic        hit;
        logic        miss;
        logic        evicted;
        logic        is_last;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } t_cache_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [ADDR_W-1:0]      s_axis_tdata;
    logic [KIND_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    set_assoc_lru_cache_sim dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the cache state and configuration
    logic        line_valid [NLINES];
    logic [31:0] line_tag   [NLINES];
    logic [2:0]  line_age   [NLINES];
    logic [31:0] hit_cnt, miss_cnt, evict_cnt;
    logic [3:0]  cfg_set_bits;
    logic [4:0]  cfg_offset_bits;
    logic [3:0]  cfg_ways;

    t_cache_result expected_results[$];
    logic [31:0]   addr_pool[$];
    int            errors = 0;
    int            cycle_count = 0;
    int            burst_left = 0;
    logic [15:0]   rcv_tick = '0;
    int            stall_left = 0;
    logic          stall_level = 1'b1;

    function automatic int unsigned eff_set_bits();
        return (int'(cfg_set_bits) > SET_BITS_MAX) ? SET_BITS_MAX : int'(cfg_set_bits);
    endfunction

    function automatic int unsigned eff_ways();
        if (cfg_ways == 4'd0) return 1;
        return (int'(cfg_ways) > NWAYS) ? NWAYS : int'(cfg_ways);
    endfunction

    // Make one way the most recent; younger valid ways age by one, saturating
    task automatic promote_way(input int unsigned base_i, input int unsigned nw,
                               input int unsigned way, input int unsigned old_rank);
        for (int unsigned j = 0; j < nw; j++) begin
            if (j != way && line_valid[base_i+j] && line_age[base_i+j] < old_rank &&
                line_age[base_i+j] < RANK_MAX)
                line_age[base_i+j] = line_age[base_i+j] + 3'd1;
        end
        line_age[base_i+way] = '0;
    endtask

    // Predict one access and queue its result
    task automatic cache_access(input logic [31:0] addr, input logic is_last);
        int unsigned   sb, nw, ob, sh, set_i, base_i, target;
        logic [63:0]   wide;
        logic [31:0]   tg;
        bit            found;
        t_cache_result r;
        sb     = eff_set_bits();
        nw     = eff_ways();
        ob     = int'(cfg_offset_bits);
        wide   = {32'd0, addr};
        set_i  = 32'((wide >> ob) & ((64'd1 << sb) - 64'd1));
        sh     = ob + sb;
        tg     = (sh >= 32) ? 32'd0 : 32'(wide >> sh);
        base_i = set_i * NWAYS;
        found  = 1'b0;
        target = 0;
        r      = '0;
        for (int unsigned j = 0; j < nw; j++) begin
            if (!found && line_valid[base_i+j] && line_tag[base_i+j] == tg) begin
                found  = 1'b1;
                target = j;
            end
        end
        if (found) begin
            promote_way(base_i, nw, target, line_age[base_i+target]);
            r.hit   = 1'b1;
            hit_cnt = hit_cnt + 32'd1;
        end else begin
            r.miss   = 1'b1;
            miss_cnt = miss_cnt + 32'd1;
            for (int unsigned j = 0; j < nw; j++) begin
                if (!found && !line_valid[base_i+j]) begin
                    found  = 1'b1;
                    target = j;
                end
            end
            if (found) begin
                promote_way(base_i, nw, target, RANK_FRESH);
            end else begin
                // oldest way wins; lowest index on a tie
                target = 0;
                for (int unsigned j = 1; j < nw; j++)
                    if (line_age[base_i+j] > line_age[base_i+target]) target = j;
                r.evicted = 1'b1;
                evict_cnt = evict_cnt + 32'd1;
                promote_way(base_i, nw, target, line_age[base_i+target]);
            end
            line_valid[base_i+target] = 1'b1;
            line_tag[base_i+target]   = tg;
        end
        r.is_last     = is_last;
        r.hit_total   = hit_cnt;
        r.miss_total  = miss_cnt;
        r.evict_total = evict_cnt;
        expected_results.push_back(r);
    endtask

    // Send one input item, bursts separated by random gaps
    task automatic send_item(input t_kind kind, input logic [31:0] addr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= addr;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        case (kind)
            KIND_LOAD, KIND_STORE: cache_access(addr, 1'b1);
            KIND_MODIFY: begin
                cache_access(addr, 1'b0);
                cache_access(addr, 1'b1);
            end
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Stop sending and wait until the block has gone quiet
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [4:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SET_BITS:    cfg_set_bits    = data[3:0];
            CFG_OFFSET_BITS: cfg_offset_bits = data;
            CFG_WAYS:        cfg_ways        = data[3:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Idle the block, then write all three registers back to back
    task automatic configure(input logic [4:0] sb, input logic [4:0] ob, input logic [4:0] nw);
        drain();
        cfg_write(CFG_SET_BITS, sb);
        cfg_write(CFG_OFFSET_BITS, ob);
        cfg_write(CFG_WAYS, nw);
        i_cfg_valid <= 1'b0;
    endtask

    // Hits, misses, a modify pair and an ignored kind
    task automatic test_basic_access();
        configure(5'd2, 5'd4, 5'd2);
        send_item(KIND_LOAD,   32'h0000_0000);
        send_item(KIND_LOAD,   32'h0000_000F);
        send_item(KIND_STORE,  32'hFFFF_FFFF);
        send_item(KIND_MODIFY, 32'h0000_0010);
        send_item(KIND_UNUSED, 32'h1234_5678);
    endtask

    // Replacement order in set 0, including an eviction while the ways are shrunk to one
    task automatic test_lru_order();
        send_item(KIND_LOAD,  32'h0000_0040);
        send_item(KIND_LOAD,  32'h0000_0000);
        send_item(KIND_LOAD,  32'h0000_0080);
        send_item(KIND_STORE, 32'h0000_0000);
        // with one way in use the second way is neither aged nor evicted
        configure(5'd2, 5'd4, 5'd1);
        send_item(KIND_LOAD,  32'h0000_00C0);
        configure(5'd2, 5'd4, 5'd2);
        send_item(KIND_LOAD,  32'h0000_0100);
    endtask

    // Set bits above the maximum, tag shifted out, ways zero and above the maximum
    task automatic test_config_edges();
        configure(5'd15, 5'd31, 5'd0);
        send_item(KIND_LOAD,   32'hFFFF_FFFF);
        send_item(KIND_LOAD,   32'h7FFF_FFFF);
        send_item(KIND_STORE,  32'h8000_0000);
        configure(5'd8, 5'd24, 5'd15);
        send_item(KIND_LOAD,   32'hAB00_0000);
        send_item(KIND_STORE,  32'hAB12_3456);
        send_item(KIND_MODIFY, 32'h0000_0000);
        send_item(KIND_UNUSED, 32'hFFFF_FFFF);
        configure(5'd0, 5'd0, 5'd8);
        send_item(KIND_LOAD,   32'hFFFF_FFFF);
        send_item(KIND_LOAD,   32'h0000_0000);
        send_item(KIND_MODIFY, 32'hDEAD_BEEF);
    endtask

    // Small working set of block addresses spread over a few sets
    task automatic build_pool();
        int unsigned sb, ob, n;
        logic [63:0] tg, st;
        sb = eff_set_bits();
        ob = int'(cfg_offset_bits);
        n  = $urandom_range(2, 20);
        addr_pool.delete();
        repeat (n) begin
            tg = ($urandom_range(0, 3) == 0) ? {32'd0, $urandom} :
                                               64'($urandom_range(0, 7));
            st = 64'($urandom_range(0, 3));
            addr_pool.push_back(32'((tg << (ob + sb)) | (st << ob)));
        end
    endtask

    // Phases of random traffic, each under its own configuration
    task automatic test_random_traffic();
        int          r;
        logic [31:0] addr;
        logic [63:0] offs_mask;
        t_kind       kind;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: configure(5'd0, 5'd0, 5'd1);
                1: configure(5'd8, 5'd24, 5'd8);
                2: configure(5'd15, 5'd31, 5'd15);
                3: configure(5'd0, 5'd31, 5'd0);
                4: configure(5'd1, 5'd2, 5'd2);
                // upper data bit on the set register is dropped
                5: configure(5'($urandom_range(16, 31)), 5'($urandom_range(0, 8)),
                             5'($urandom_range(1, 8)));
                default: configure(5'($urandom_range(0, 9)), 5'($urandom_range(0, 12)),
                                   5'($urandom_range(0, 9)));
            endcase
            build_pool();
            offs_mask = (64'd1 << cfg_offset_bits) - 64'd1;
            repeat (PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    kind = KIND_UNUSED;
                    addr = $urandom;
                end else if (r < 75) begin
                    kind = t_kind'($urandom_range(0, 2));
                    addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)] |
                           32'({32'd0, $urandom} & offs_mask);
                end else begin
                    kind = t_kind'($urandom_range(0, 2));
                    addr = $urandom;
                end
                send_item(kind, addr);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_cache_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual tdata %0h tlast %0b",
                         $time, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("hit",         32'(exp_r.hit),     32'(m_axis_tdata[0]));
                check_field("miss",        32'(exp_r.miss),    32'(m_axis_tdata[1]));
                check_field("evicted",     32'(exp_r.evicted), 32'(m_axis_tdata[2]));
                check_field("hit_total",   exp_r.hit_total,    m_axis_tdata[34:3]);
                check_field("miss_total",  exp_r.miss_total,   m_axis_tdata[66:35]);
                check_field("evict_total", exp_r.evict_total,  m_axis_tdata[98:67]);
                check_field("tlast",       32'(exp_r.is_last), 32'(m_axis_tlast));
            end
        end
    end

    // Receiver stall pattern: free running, random, periodic, long stalls
    always @(negedge i_clk) begin
        rcv_tick <= rcv_tick + 16'd1;
        case (rcv_tick[10:9])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_axis_tready <= ((rcv_tick % 6) < 4);
            default: begin
                if (stall_left == 0) begin
                    stall_left  = $urandom_range(1, 12);
                    stall_level = ~stall_level;
                end
                stall_left--;
                m_axis_tready <= stall_level;
            end
        endcase
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_set_assoc_lru_cache_sim NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_LOAD;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_SET_BITS;
        i_cfg_data    = '0;
        for (int k = 0; k < NLINES; k++) begin
            line_valid[k] = 1'b0;
            line_age[k]   = '0;
        end
        hit_cnt         = '0;
        miss_cnt        = '0;
        evict_cnt       = '0;
        cfg_set_bits    = 4'd0;
        cfg_offset_bits = 5'd0;
        cfg_ways        = 4'd1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_access();
        test_lru_order();
        test_config_edges();
        test_random_traffic();

        drain();
        if (errors == 0)
            $display("tb_set_assoc_lru_cache_sim OK");
        else
            $display("tb_set_assoc_lru_cache_sim NOT OK");
        $finish;
    end

endmodule
